FILE: hdl/base64_packet_decode_check_defines.svh
// Assertion macros shared by the checker of the base64 reply decoder.
// Depends on nothing; included by the files that assert.
`ifndef BASE64_PACKET_DECODE_CHECK_DEFINES_SVH
`define BASE64_PACKET_DECODE_CHECK_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define B64PC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("b64pc assertion failed");

// Checks that cons holds in the cycle after ante.
`define B64PC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("b64pc assertion failed");

`endif

FILE: hdl/b64pc_pkg.sv
// Types, constants and the character table of the base64 reply decoder.
// Depends on nothing; used by every module of the block but the checker.
package b64pc_pkg;

	localparam int MAX_CHARS_DEF = 1024;
	localparam int JOB_DEPTH = 4;
	localparam logic [9:0] EXPECTED_RESET = 10'd200;

	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPA   = 8'h41;
	localparam logic [7:0] CHAR_UPZ   = 8'h5A;
	localparam logic [7:0] CHAR_LOA   = 8'h61;
	localparam logic [7:0] CHAR_LOZ   = 8'h7A;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	localparam logic [1:0] IDX_STATUS = 2'd3;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_BAD = 2'd2,
		ST_SUM = 2'd3
	} status_t;

	typedef struct packed {
		logic        has_data;
		logic [23:0] bytes;
		logic        has_status;
		status_t     status;
	} job_t;

	// Returns {mapped, value}; mapped is low for any character outside the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
			r = {1'b1, 6'(c - CHAR_UPA)};
		end else if (c >= CHAR_LOA && c <= CHAR_LOZ) begin
			r = {1'b1, 6'(c - CHAR_LOA + 8'd26)};
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			r = {1'b1, 6'(c - CHAR_ZERO + 8'd52)};
		end else if (c == CHAR_PLUS) begin
			r = {1'b1, SEXTET_PLUS};
		end else if (c == CHAR_SLASH) begin
			r = {1'b1, SEXTET_SLASH};
		end
		return r;
	endfunction

endpackage

FILE: hdl/b64pc_front.sv
// Front end: takes characters, decodes sextets, tracks the reply and queues jobs.
// Depends on b64pc_pkg.
module b64pc_front #(
	parameter int MAX_CHARS = b64pc_pkg::MAX_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [9:0]        cfg_data,
	input  logic              accept,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              push,
	output b64pc_pkg::job_t   job
);
	import b64pc_pkg::*;

	localparam int CW = $clog2(MAX_CHARS + 2);
	localparam int CMPW = (CW > 10) ? CW : 10;

	logic [9:0]    expected_q;
	logic [17:0]   buf_q;
	logic [1:0]    pos_q;
	logic [CW-1:0] count_q;
	logic [7:0]    xor_q;
	logic          bad_q;

	logic [6:0]    sx;
	logic          drop;
	logic          bad_n;
	logic [CW-1:0] count_n;
	logic [23:0]   group;
	logic          emit;
	logic [7:0]    xor_n;
	status_t       st;

	always_comb begin
		sx = sextet_of(char_code);
		drop = last_char && (char_code == CHAR_HASH);
		bad_n = bad_q || (!drop && !sx[6]);
		count_n = count_q;
		if (!drop && count_q <= CW'(MAX_CHARS)) begin
			count_n = count_q + 1'b1;
		end
		group = {buf_q, sx[5:0]};
		emit = !drop && (pos_q == 2'd3) && !bad_n;
		xor_n = xor_q;
		if (emit) begin
			xor_n = xor_q ^ group[23:16] ^ group[15:8] ^ group[7:0];
		end
		priority if (count_n == '0 || CMPW'(count_n) != CMPW'(expected_q)
				|| count_n[1:0] != 2'd0) begin
			st = ST_LEN;
		end else if (bad_n) begin
			st = ST_BAD;
		end else if (xor_n != 8'd0) begin
			st = ST_SUM;
		end else begin
			st = ST_OK;
		end
	end

	assign push = accept && (emit || last_char);
	assign job = '{has_data: emit, bytes: group, has_status: last_char, status: st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= EXPECTED_RESET;
		end else if (cfg_write) begin
			expected_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			pos_q   <= '0;
			count_q <= '0;
			xor_q   <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				buf_q   <= '0;
				pos_q   <= '0;
				count_q <= '0;
				xor_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				xor_q   <= xor_n;
				bad_q   <= bad_n;
				if (pos_q == 2'd3) begin
					buf_q <= '0;
					pos_q <= '0;
				end else begin
					buf_q <= group[17:0];
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: hdl/b64pc_fifo.sv
// Short job queue between the front and back ends.
// Depends on b64pc_pkg.
module b64pc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64pc_pkg::job_t wr_job,
	input  logic            pop,
	output b64pc_pkg::job_t rd_job,
	output logic            full,
	output logic            nonempty
);
	import b64pc_pkg::*;

	localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int NW = $clog2(JOB_DEPTH + 1);

	job_t          mem_q [JOB_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign rd_job = mem_q[rd_ptr_q];
	assign full = (count_q == NW'(JOB_DEPTH));
	assign nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/b64pc_back.sv
// Back end: takes jobs from the queue and sends their bytes and status word by word.
// Depends on b64pc_pkg.
module b64pc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_avail,
	input  b64pc_pkg::job_t head_job,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic [1:0]      status,
	output logic            last
);
	import b64pc_pkg::*;

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       take;
	logic       final_word;

	assign take = busy_q && !out_stall;
	assign final_word = (idx_q == IDX_STATUS) || (idx_q == 2'd2 && !job_q.has_status);
	assign pop = job_avail && (!busy_q || (take && final_word));

	assign out_valid = busy_q;
	assign kind = (idx_q == IDX_STATUS);
	assign last = kind;
	assign status = kind ? job_q.status : 2'd0;

	always_comb begin
		unique case (idx_q)
			2'd0:    data_byte = job_q.bytes[23:16];
			2'd1:    data_byte = job_q.bytes[15:8];
			2'd2:    data_byte = job_q.bytes[7:0];
			default: data_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= head_job.has_data ? 2'd0 : IDX_STATUS;
		end else if (take) begin
			if (final_word) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/base64_packet_decode_check.sv
// Base64 reply decoder with XOR checksum: one character is taken per cycle unless stalled.
// A completed group or final character is queued, then held in the back end's job register.
// Output: one word per cycle unless stalled; a four-entry queue sets how far input may lead.
// Sustained input rate is one character per cycle while the output side keeps up.
// Reset clears the reply state and the queue and sets the expected character count to 200.
module base64_packet_decode_check #(
	parameter int MAX_CHARS = b64pc_pkg::MAX_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       last
);
	import b64pc_pkg::*;

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic nonempty;
	job_t wr_job;
	job_t rd_job;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !full;

	b64pc_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.accept(accept),
		.char_code(char_code),
		.last_char(last_char),
		.push(push),
		.job(wr_job)
	);

	b64pc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.rd_job(rd_job),
		.full(full),
		.nonempty(nonempty)
	);

	b64pc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_avail(nonempty),
		.head_job(rd_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.status(status),
		.last(last)
	);

endmodule

FILE: hdl/b64pc_checker.sv
// Port-level checks for the base64 reply decoder, bound to its top level.
// Depends on base64_packet_decode_check_defines.svh.
`include "base64_packet_decode_check_defines.svh"

module b64pc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [7:0] data_byte,
	input logic [1:0] status,
	input logic       last
);

	`B64PC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({kind, data_byte, status, last}))
	`B64PC_ASSERT_NOW(a_last_is_status, clk, arst_n, out_valid, kind == last)
	`B64PC_ASSERT_NOW(a_status_word_clean, clk, arst_n, out_valid && kind, data_byte == 8'd0)
	`B64PC_ASSERT_NOW(a_data_word_clean, clk, arst_n, out_valid && !kind, status == 2'd0)

endmodule

bind base64_packet_decode_check b64pc_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.data_byte(data_byte),
	.status(status),
	.last(last)
);
